// ===== sv/rgba_to_ycbcr420_planar_writer_top_macros.svh =====
// Assertion macros shared by the RGB to YCbCr 4:2:0 planar writer RTL.
`ifndef RGBA_TO_YCBCR420_PLANAR_WRITER_TOP_MACROS_SVH
`define RGBA_TO_YCBCR420_PLANAR_WRITER_TOP_MACROS_SVH

// Plain property check, clocked on clk_i and quiet during reset.
`define RYW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check, clocked on clk_i and quiet during reset.
`define RYW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, clocked on clk_i and quiet during reset.
`define RYW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ryw_pkg.sv =====
// Types and constants of the RGB to YCbCr 4:2:0 planar writer.
package ryw_pkg;

  // Target plane of one write transfer.
  typedef enum logic [1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } ryw_plane_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_LUMA_STRIDE   = 3'd2,
    CFG_CHROMA_STRIDE = 3'd3,
    CFG_CHROMA_STEP   = 3'd4,
    CFG_LUMA_BASE     = 3'd5,
    CFG_CR_BASE       = 3'd6,
    CFG_CB_BASE       = 3'd7
  } ryw_cfg_e;

  // JFIF integer coefficients, magnitudes only; signs are applied in the datapath.
  localparam logic [7:0] Y_R  = 8'd77;
  localparam logic [7:0] Y_G  = 8'd150;
  localparam logic [7:0] Y_B  = 8'd29;
  localparam logic [7:0] CB_R = 8'd43;
  localparam logic [7:0] CB_G = 8'd85;
  localparam logic [7:0] CR_G = 8'd107;
  localparam logic [7:0] CR_B = 8'd21;

  // Chroma bias of 128 placed ahead of the shift by 8.
  localparam logic [16:0] CHROMA_BIAS = 17'd32768;

  // Field widths fixed by the stream format.
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

endpackage

// ===== sv/rgba_to_ycbcr420_planar_writer_top.sv =====
// Top level of the RGB to YCbCr 4:2:0 planar writer.
//
// Usage:
//   Pixels enter on the s_axis channel in raster order, one transfer per pixel,
//   red in tdata[7:0], green in [15:8], blue in [23:16]. Each pixel produces one
//   luma write on m_axis; a pixel on an even row and even column then produces a
//   Cb write and a Cr write. tlast marks the final write of a pixel; tuser holds
//   the target plane and a flag set on every write of the final pixel of a frame.
//   Frame geometry and plane addresses come from the cfg write port; write it
//   only while no pixel is in flight.
//   The first write of a pixel is offered from the result register, which loads
//   the pixel from the input register once the result register is free.
//   The single result port serializes up to three writes per pixel, a luma write
//   alone or a luma, a Cb and a Cr write, and the result register loads the next
//   pixel as the last write of the current one leaves.
//   The input register takes a new pixel while the result register still holds
//   writes, so a stalled receiver backs up into s_axis_tready_o after one pixel.
//   Reset empties both registers, zeroes the column and row counters and loads
//   the default geometry of 640 by 480.
`include "rgba_to_ycbcr420_planar_writer_top_macros.svh"

module rgba_to_ycbcr420_planar_writer_top #(
  parameter int unsigned MAX_WIDTH  = 8192,
  parameter int unsigned MAX_HEIGHT = 8192,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  ryw_pkg::ryw_cfg_e                cfg_idx_i,
  input  logic [31:0]                      cfg_wdata_i,
  // Pixel input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ryw_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // red, green, blue
  // Write output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [ryw_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,  // write_addr, sample_value
  output logic                             m_axis_tlast_o,  // last_of_run
  output logic [ryw_pkg::OUT_USER_W-1:0]   m_axis_tuser_o   // plane_sel, frame_done
);
  import ryw_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned RW1 = RW + 1;
  localparam int unsigned LRO_W = RW + 16;
  localparam int unsigned CRO_W = RW + 15;
  localparam int unsigned CCO_W = CW + 2;
  localparam logic [OUT_ADDR_W-1:0] AMASK = (ADDR_BITS >= OUT_ADDR_W) ? '1 :
      OUT_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  // Configuration registers.
  logic [13:0] frame_width_q, frame_height_q;
  logic [15:0] luma_stride_q, chroma_stride_q;
  logic [2:0]  chroma_step_q;
  logic [31:0] luma_base_q, cr_base_q, cb_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= 14'd640;
      frame_height_q  <= 14'd480;
      luma_stride_q   <= 16'd640;
      chroma_stride_q <= 16'd640;
      chroma_step_q   <= 3'd2;
      luma_base_q     <= '0;
      cr_base_q       <= '0;
      cb_base_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_wdata_i[13:0];
        CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_wdata_i[13:0];
        CFG_LUMA_STRIDE:   luma_stride_q   <= cfg_wdata_i[15:0];
        CFG_CHROMA_STRIDE: chroma_stride_q <= cfg_wdata_i[15:0];
        CFG_CHROMA_STEP:   chroma_step_q   <= cfg_wdata_i[2:0];
        CFG_LUMA_BASE:     luma_base_q     <= cfg_wdata_i;
        CFG_CR_BASE:       cr_base_q       <= cfg_wdata_i;
        CFG_CB_BASE:       cb_base_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, large values saturate.
  logic [CW1-1:0] width_eff;
  logic [RW1-1:0] height_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = CW1'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      width_eff = CW1'(MAX_WIDTH);
    end else begin
      width_eff = CW1'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_eff = RW1'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      height_eff = RW1'(MAX_HEIGHT);
    end else begin
      height_eff = RW1'(frame_height_q);
    end
  end

  // Pipeline handshake signals.
  logic s_xfer, m_xfer, a_valid_q, b_valid_q, b_free, b_last;

  // Raster position counters, advanced on every input transfer.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          wrap_col, wrap_row;

  assign s_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign wrap_col = (CW1'({1'b0, col_q}) + CW1'(1)) >= width_eff;
  assign wrap_row = (RW1'({1'b0, row_q}) + RW1'(1)) >= height_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (s_xfer) begin
      if (wrap_col) begin
        col_d = '0;
        row_d = wrap_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input register: pixel plus its position and flags.
  logic [7:0]    a_red_q, a_green_q, a_blue_q;
  logic [CW-1:0] a_col_q;
  logic [RW-1:0] a_row_q;
  logic          a_done_q;

  assign s_axis_tready_o = !a_valid_q || b_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      a_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      a_red_q   <= s_axis_tdata_i[7:0];
      a_green_q <= s_axis_tdata_i[15:8];
      a_blue_q  <= s_axis_tdata_i[23:16];
      a_col_q   <= col_q;
      a_row_q   <= row_q;
      a_done_q  <= wrap_col && wrap_row;
    end
  end

  // Color conversion; every sum stays in range or wraps back into it.
  logic [15:0] y_sum;
  logic [16:0] cb_sum, cr_sum;
  logic        a_chroma;

  assign a_chroma = !a_row_q[0] && !a_col_q[0];
  assign y_sum  = 16'(Y_R * a_red_q) + 16'(Y_G * a_green_q) + 16'(Y_B * a_blue_q);
  assign cb_sum = CHROMA_BIAS + {2'b0, a_blue_q, 7'd0}
                  - 17'(CB_R * a_red_q) - 17'(CB_G * a_green_q);
  assign cr_sum = CHROMA_BIAS + {2'b0, a_red_q, 7'd0}
                  - 17'(CR_G * a_green_q) - 17'(CR_B * a_blue_q);

  // Address generation.
  logic [LRO_W-1:0]      luma_row_off;
  logic [CRO_W-1:0]      chroma_row_off;
  logic [CCO_W-1:0]      chroma_col_off;
  logic [OUT_ADDR_W-1:0] chroma_off, y_addr, cb_addr, cr_addr;

  assign luma_row_off   = LRO_W'(a_row_q) * LRO_W'(luma_stride_q);
  assign chroma_row_off = CRO_W'(a_row_q >> 1) * CRO_W'(chroma_stride_q);
  assign chroma_col_off = CCO_W'(a_col_q >> 1) * CCO_W'(chroma_step_q);
  assign chroma_off     = OUT_ADDR_W'(chroma_row_off) + OUT_ADDR_W'(chroma_col_off);
  assign y_addr  = (luma_base_q + OUT_ADDR_W'(luma_row_off) + OUT_ADDR_W'(a_col_q)) & AMASK;
  assign cb_addr = (cb_base_q + chroma_off) & AMASK;
  assign cr_addr = (cr_base_q + chroma_off) & AMASK;

  // Result register: the writes of one pixel, sent one per transfer.
  logic [SAMPLE_W-1:0]   b_y_q, b_cb_q, b_cr_q;
  logic [OUT_ADDR_W-1:0] b_y_addr_q, b_cb_addr_q, b_cr_addr_q;
  logic                  b_chroma_q, b_done_q;
  ryw_plane_e            idx_q;

  assign m_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign b_last = !b_chroma_q || (idx_q == PLANE_CR);
  assign b_free = !b_valid_q || (m_xfer && b_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      idx_q     <= PLANE_Y;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
      idx_q     <= PLANE_Y;
    end else if (m_xfer) begin
      idx_q <= (idx_q == PLANE_Y) ? PLANE_CB : PLANE_CR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_valid_q) begin
      b_y_q       <= y_sum[15:8];
      b_cb_q      <= cb_sum[15:8];
      b_cr_q      <= cr_sum[15:8];
      b_y_addr_q  <= y_addr;
      b_cb_addr_q <= cb_addr;
      b_cr_addr_q <= cr_addr;
      b_chroma_q  <= a_chroma;
      b_done_q    <= a_done_q;
    end
  end

  // Output selection by plane.
  logic [SAMPLE_W-1:0]   out_sample;
  logic [OUT_ADDR_W-1:0] out_addr;

  always_comb begin
    unique case (idx_q)
      PLANE_Y: begin
        out_sample = b_y_q;
        out_addr   = b_y_addr_q;
      end
      PLANE_CB: begin
        out_sample = b_cb_q;
        out_addr   = b_cb_addr_q;
      end
      PLANE_CR: begin
        out_sample = b_cr_q;
        out_addr   = b_cr_addr_q;
      end
      default: begin
        out_sample = b_y_q;
        out_addr   = b_y_addr_q;
      end
    endcase
  end

  assign m_axis_tvalid_o = b_valid_q;
  assign m_axis_tdata_o  = {out_sample, out_addr};
  assign m_axis_tlast_o  = b_last;
  assign m_axis_tuser_o  = {b_done_q, idx_q};

  // Checks on the sequencing of writes, the raster counters and the input handshake.
  `RYW_ASSERT_IMP(a_luma_only_idx, b_valid_q && !b_chroma_q, idx_q == PLANE_Y,
                  "luma-only pixel advanced past its luma write")
  `RYW_ASSERT_NXT(a_stall_holds_idx, m_axis_tvalid_o && !m_axis_tready_i, $stable(idx_q),
                  "plane index moved while the receiver stalled")
  `RYW_ASSERT_NXT(a_col_wraps, s_xfer && wrap_col, col_q == '0,
                  "column counter did not wrap at the end of a row")
  `RYW_ASSERT_IMP(a_ready_when_empty, !a_valid_q, s_axis_tready_o,
                  "input not ready with an empty input register")
endmodule

// ===== test/ryw_stream_checker.sv =====
// Watches the pixel and write streams of the planar writer and checks every write.
`timescale 1ns / 1ps

module ryw_stream_checker
  import ryw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  ryw_cfg_e              cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // red, green, blue
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,  // write_addr, sample_value
  input  logic                  m_axis_tlast_i,  // last_of_run
  input  logic [OUT_USER_W-1:0] m_axis_tuser_i,  // plane_sel, frame_done
  output int                    err_cnt_o,
  output int                    pending_o,
  output int                    pix_cnt_o,
  output int                    write_cnt_o,
  output int                    chroma_cnt_o,
  output int                    frame_cnt_o
);

  localparam int unsigned MAX_W = 8192;
  localparam int unsigned MAX_H = 8192;

  // One plane write as it should leave the block.
  typedef struct {
    ryw_plane_e  plane;
    logic [31:0] addr;
    logic [7:0]  sample;
    logic        last;
    logic        done;
  } plane_write_t;

  plane_write_t pending_writes[$];

  // Local copy of the register file and of the raster position.
  logic [13:0] width_reg;
  logic [13:0] height_reg;
  logic [15:0] luma_stride_reg;
  logic [15:0] chroma_stride_reg;
  logic [2:0]  chroma_step_reg;
  logic [31:0] luma_base_reg;
  logic [31:0] cr_base_reg;
  logic [31:0] cb_base_reg;
  int unsigned col_pos;
  int unsigned row_pos;

  // A size of zero counts as one; anything above the maximum saturates.
  function automatic int unsigned clip_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Works out the writes of one pixel and advances the raster position.
  task automatic predict_writes(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    bit wrap_col;
    bit done;
    bit chroma;
    int ri;
    int gi;
    int bi;
    logic [31:0] off;
    plane_write_t wr;
    w = clip_size(int'(width_reg), MAX_W);
    h = clip_size(int'(height_reg), MAX_H);
    col = col_pos;
    row = row_pos;
    ri = r;
    gi = g;
    bi = b;
    wrap_col = (col + 1 >= w);
    done = wrap_col && (row + 1 >= h);
    chroma = (row[0] == 1'b0) && (col[0] == 1'b0);

    // Luma always comes first.
    wr.plane = PLANE_Y;
    wr.addr = luma_base_reg + row * 32'(luma_stride_reg) + col;
    wr.sample = 8'((77 * ri + 150 * gi + 29 * bi) >> 8);
    wr.last = !chroma;
    wr.done = done;
    pending_writes.push_back(wr);

    // Even row and even column: Cb then Cr, bias folded in ahead of the floor shift.
    if (chroma) begin
      off = (row >> 1) * 32'(chroma_stride_reg) + (col >> 1) * 32'(chroma_step_reg);
      wr.plane = PLANE_CB;
      wr.addr = cb_base_reg + off;
      wr.sample = 8'((-43 * ri - 85 * gi + 128 * bi + 32768) >> 8);
      wr.last = 1'b0;
      pending_writes.push_back(wr);
      wr.plane = PLANE_CR;
      wr.addr = cr_base_reg + off;
      wr.sample = 8'((128 * ri - 107 * gi - 21 * bi + 32768) >> 8);
      wr.last = 1'b1;
      pending_writes.push_back(wr);
      chroma_cnt_o++;
    end

    if (done) frame_cnt_o++;
    if (wrap_col) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plane_write_t wr;
    if (!rst_ni) begin
      width_reg         = 14'd640;
      height_reg        = 14'd480;
      luma_stride_reg   = 16'd640;
      chroma_stride_reg = 16'd640;
      chroma_step_reg   = 3'd2;
      luma_base_reg     = '0;
      cr_base_reg       = '0;
      cb_base_reg       = '0;
      col_pos = 0;
      row_pos = 0;
      pending_writes.delete();
      err_cnt_o = 0;
      pending_o = 0;
      pix_cnt_o = 0;
      write_cnt_o = 0;
      chroma_cnt_o = 0;
      frame_cnt_o = 0;
    end else begin
      // Register writes are to land only while the block is idle; the checker does not enforce it.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:   width_reg         = cfg_wdata_i[13:0];
          CFG_FRAME_HEIGHT:  height_reg        = cfg_wdata_i[13:0];
          CFG_LUMA_STRIDE:   luma_stride_reg   = cfg_wdata_i[15:0];
          CFG_CHROMA_STRIDE: chroma_stride_reg = cfg_wdata_i[15:0];
          CFG_CHROMA_STEP:   chroma_step_reg   = cfg_wdata_i[2:0];
          CFG_LUMA_BASE:     luma_base_reg     = cfg_wdata_i;
          CFG_CR_BASE:       cr_base_reg       = cfg_wdata_i;
          CFG_CB_BASE:       cb_base_reg       = cfg_wdata_i;
          default: ;
        endcase
      end

      // Each write transfer is matched against the oldest prediction.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        write_cnt_o++;
        if (pending_writes.size() == 0) begin
          $error("write transfer with no prediction waiting: tdata 0x%0h", m_axis_tdata_i);
          err_cnt_o++;
        end else begin
          wr = pending_writes.pop_front();
          check_field("plane_sel", 32'(wr.plane), 32'(m_axis_tuser_i[1:0]));
          check_field("write_addr", wr.addr, m_axis_tdata_i[31:0]);
          check_field("sample_value", 32'(wr.sample), 32'(m_axis_tdata_i[39:32]));
          check_field("last_of_run", 32'(wr.last), 32'(m_axis_tlast_i));
          check_field("frame_done", 32'(wr.done), 32'(m_axis_tuser_i[2]));
        end
      end

      // Each pixel transfer adds its predicted writes.
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pix_cnt_o++;
        predict_writes(s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]);
      end
      pending_o = pending_writes.size();
    end
  end

endmodule

// ===== test/rgba_to_ycbcr420_planar_writer_top_tb.sv =====
// Stimulus and verdict for the RGB to YCbCr 4:2:0 planar writer.
`timescale 1ns / 1ps

module rgba_to_ycbcr420_planar_writer_top_tb;
  import ryw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned STALL_CYCLES = 250;
  localparam int unsigned NUM_PHASES = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  ryw_cfg_e              cfg_idx_i;
  logic [31:0]           cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;   // red, green, blue
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // write_addr, sample_value
  logic                  m_axis_tlast_o;   // last_of_run
  logic [OUT_USER_W-1:0] m_axis_tuser_o;   // plane_sel, frame_done

  int err_cnt;
  int pending;
  int pix_cnt;
  int write_cnt;
  int chroma_cnt;
  int frame_cnt;

  int unsigned cycle_cnt;
  int unsigned settings_cnt;
  int unsigned idle_pct;
  logic        quiet;
  logic        stall_req;
  logic        stall_done;

  rgba_to_ycbcr420_planar_writer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  ryw_stream_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending),
    .pix_cnt_o       (pix_cnt),
    .write_cnt_o     (write_cnt),
    .chroma_cnt_o    (chroma_cnt),
    .frame_cnt_o     (frame_cnt)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("rgba_to_ycbcr420_planar_writer_top_tb: done, errors");
      $finish;
    end
  end

  // Write receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    m_axis_tready_i = 1'b0;
    stall_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (stall_req && !stall_done) begin
        m_axis_tready_i <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        stall_done = 1'b1;
      end else if (quiet) begin
        m_axis_tready_i <= 1'b1;
        @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk_i);
        if ($urandom_range(0, 2) != 0) begin
          m_axis_tready_i <= 1'b0;
          repeat ($urandom_range(1, 17)) @(negedge clk_i);
        end
      end
    end
  end

  // Offers one pixel and returns on the falling edge after its transfer.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, g, r};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Holds the input quiet until every predicted write has come out.
  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input ryw_cfg_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  // Writes the full register file, one register per cycle.
  task automatic program_regs(input logic [13:0] w, input logic [13:0] h,
                              input logic [15:0] luma_stride, input logic [15:0] chroma_stride,
                              input logic [2:0] step, input logic [31:0] luma_base,
                              input logic [31:0] cr_base, input logic [31:0] cb_base);
    cfg_write(CFG_FRAME_WIDTH, 32'(w));
    cfg_write(CFG_FRAME_HEIGHT, 32'(h));
    cfg_write(CFG_LUMA_STRIDE, 32'(luma_stride));
    cfg_write(CFG_CHROMA_STRIDE, 32'(chroma_stride));
    cfg_write(CFG_CHROMA_STEP, 32'(step));
    cfg_write(CFG_LUMA_BASE, luma_base);
    cfg_write(CFG_CR_BASE, cr_base);
    cfg_write(CFG_CB_BASE, cb_base);
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [13:0] pick_size(input int unsigned typical);
    case ($urandom_range(0, 11))
      0: return 14'd0;
      1: return 14'h3FFF;
      2: return 14'd8192;
      default: return 14'($urandom_range(1, typical));
    endcase
  endfunction

  function automatic logic [15:0] pick_stride;
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 32));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_base;
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Corner colors: black, white, primaries, secondaries, greys and near-limits.
  logic [23:0] corner_rgb [12] = '{
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h00FFFF,
    24'hFFFF00, 24'hFF00FF, 24'h808080, 24'h040201, 24'h7F7F7F, 24'hFBFDFE
  };

  initial begin
    int unsigned n;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_FRAME_WIDTH;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    quiet           = 1'b0;
    stall_req       = 1'b0;
    idle_pct        = 25;
    cycle_cnt       = 0;
    settings_cnt    = 0;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 3x3 frame: odd width, chroma on even columns of even rows, a frame end and a wrap.
    program_regs(14'd3, 14'd3, 16'd5, 16'd4, 3'd4, 32'h0000_1000, 32'h0000_2000,
                 32'h0000_3000);
    foreach (corner_rgb[i]) begin
      send_pixel(corner_rgb[i][23:16], corner_rgb[i][15:8], corner_rgb[i][7:0]);
    end
    drain();

    // Zero sizes act as a 1x1 frame; the row counter sits beyond the new height.
    program_regs(14'd0, 14'd0, 16'hFFFF, 16'hFFFF, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h55);
    drain();

    // Oversized width saturates; big strides and bases wrap the addresses.
    program_regs(14'h3FFF, 14'd2, 16'hFFFF, 16'hFFFF, 3'd7, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                 32'hFFFF_FFFE);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h12, 8'h34, 8'h56);
    drain();

    // Random settings, each followed by a burst of random pixels.
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_regs(pick_size(12), pick_size(8), pick_stride(), pick_stride(),
                   3'($urandom_range(0, 7)), pick_base(), pick_base(), pick_base());
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (p == 1) stall_req <= 1'b1;
      if (p == NUM_PHASES - 1) quiet <= 1'b1;
      n = $urandom_range(50, 75);
      repeat (n) begin
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
      drain();
    end

    repeat (8) @(negedge clk_i);
    $display("Covered %0d pixels and %0d writes (%0d chroma pairs, %0d frame ends)",
             pix_cnt, write_cnt, chroma_cnt, frame_cnt);
    $display("over %0d register settings, with a %0d-cycle output stall.",
             settings_cnt, STALL_CYCLES);
    if (err_cnt == 0 && pending == 0) begin
      $display("rgba_to_ycbcr420_planar_writer_top_tb: done, clean");
    end else begin
      $display("rgba_to_ycbcr420_planar_writer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
